>>> rtl/core/expression_lexer_fsm_assert.svh
// Assertion macros shared by the lexer checker.
// Depends on nothing; the including module provides clock and reset.
`ifndef EXPRESSION_LEXER_FSM_ASSERT_SVH
`define EXPRESSION_LEXER_FSM_ASSERT_SVH

// Checked at every clock edge except while reset is high.
`define EXL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked at every clock edge, reset included.
`define EXL_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

>>> rtl/core/exl_pkg.sv
// Shared types, character codes and helper functions of the expression lexer.
// Depends on nothing.
`timescale 1ns / 1ps

package exl_pkg;

   // character codes
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_Z   = 8'h7A;

   // action codes on the result
   localparam logic [1:0] ACT_SKIP   = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_NEW    = 2'd2;
   localparam logic [1:0] ACT_ERR    = 2'd3;

   // token kinds
   localparam logic [2:0] KIND_INT  = 3'd0;
   localparam logic [2:0] KIND_DEC  = 3'd1;
   localparam logic [2:0] KIND_NAME = 3'd2;
   localparam logic [2:0] KIND_OP   = 3'd3;
   localparam logic [2:0] KIND_LT   = 3'd4;
   localparam logic [2:0] KIND_LE   = 3'd5;
   localparam logic [2:0] KIND_GT   = 3'd6;
   localparam logic [2:0] KIND_GE   = 3'd7;

   localparam logic [1:0] QUEUE_DEPTH = 2'd2;

   typedef enum logic [3:0] {
      ST_INT   = 4'd0,
      ST_DEC   = 4'd1,
      ST_FRAC  = 4'd2,
      ST_NAME  = 4'd3,
      ST_OP    = 4'd4,
      ST_LT1   = 4'd5,
      ST_LT2   = 4'd6,
      ST_GT1   = 4'd7,
      ST_GT2   = 4'd8,
      ST_SPACE = 4'd9
   } lex_state_type;

   typedef enum logic [3:0] {
      CL_DIGIT = 4'd0,
      CL_ALPHA = 4'd1,
      CL_WS    = 4'd2,
      CL_OP    = 4'd3,
      CL_DOT   = 4'd4,
      CL_LT    = 4'd5,
      CL_GT    = 4'd6,
      CL_EQ    = 4'd7,
      CL_OTHER = 4'd8
   } class_type;

   typedef enum logic [2:0] {
      MV_SKIP   = 3'd0,
      MV_APPEND = 3'd1,
      MV_NEW    = 3'd2,
      MV_ERR    = 3'd3,
      MV_CLOSE  = 3'd4
   } move_type;

   // classified character as it travels from front to back
   typedef struct packed {
      logic [7:0] char_in;
      class_type  cls;
      logic       is_last;
   } item_type;

   // handshake between front queue and back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } link_type;

   typedef struct packed {
      logic [7:0] char_echo;
      logic [1:0] action;
      logic       closes_prior;
      logic [2:0] token_kind;
      logic       closes_at_end;
      logic       failed;
      logic       end_of_string;
   } rsp_type;

   function automatic class_type classify(logic [7:0] c);
      class_type cl;
      case (c) inside
         [CH_ZERO:CH_NINE]:                   cl = CL_DIGIT;
         [CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]: cl = CL_ALPHA;
         CH_SPACE, [CH_TAB:CH_CR]:            cl = CL_WS;
         CH_STAR, CH_PLUS, CH_MINUS, CH_SLASH,
         CH_LPAREN, CH_RPAREN:                cl = CL_OP;
         CH_DOT:                              cl = CL_DOT;
         CH_LT:                               cl = CL_LT;
         CH_GT:                               cl = CL_GT;
         CH_EQ:                               cl = CL_EQ;
         default:                             cl = CL_OTHER;
      endcase
      return cl;
   endfunction

   function automatic logic [2:0] kind_of(lex_state_type st);
      logic [2:0] k;
      unique case (st)
         ST_DEC, ST_FRAC: k = KIND_DEC;
         ST_NAME:         k = KIND_NAME;
         ST_OP:           k = KIND_OP;
         ST_LT1:          k = KIND_LT;
         ST_LT2:          k = KIND_LE;
         ST_GT1:          k = KIND_GT;
         ST_GT2:          k = KIND_GE;
         default:         k = KIND_INT;
      endcase
      return k;
   endfunction

endpackage

>>> rtl/core/exl_front.sv
// Front end: classifies each accepted byte and holds it in a two-entry queue.
// Depends on exl_pkg.
`timescale 1ns / 1ps

module exl_front
   import exl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_char_in,
   input  logic       req_is_last,
   output link_type   link,
   input  logic       take
);

   item_type   q_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == QUEUE_DEPTH);
   assign do_push = push && !full;
   assign do_pop  = take && (cnt_ff != 2'd0);

   assign link.valid = (cnt_ff != 2'd0);
   assign link.item  = q_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ff] <= '{char_in: req_char_in, cls: classify(req_char_in),
                          is_last: req_is_last};
      end
   end

endmodule

>>> rtl/core/exl_back.sv
// Back end: lexer state machine, error latch and two-entry result queue.
// Depends on exl_pkg.
`timescale 1ns / 1ps

module exl_back
   import exl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  link_type link,
   output logic     take,
   output logic     empty,
   input  logic     pop,
   output rsp_type  rsp
);

   lex_state_type st_ff, st_in;
   logic          err_ff, err_in;
   move_type      mv;
   lex_state_type nxt;
   logic          new_err;
   rsp_type       res;

   rsp_type       q_ff [2];
   logic          wr_ff, wr_in;
   logic          rd_ff, rd_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          do_pop;

   class_type     cl;
   logic          last;

   assign cl   = link.item.cls;
   assign last = link.item.is_last;
   assign take = link.valid && (cnt_ff != QUEUE_DEPTH);

   // transition decode
   always_comb begin
      logic err;
      logic done;
      err  = 1'b0;
      done = 1'b0;
      mv   = MV_ERR;
      nxt  = st_ff;
      if (cl == CL_OTHER) begin
         done = 1'b1;
      end else begin
         unique case (st_ff)
            ST_SPACE: begin
               if (cl == CL_WS) begin
                  mv = MV_SKIP; done = 1'b1;
               end
               err = (cl == CL_DOT) || (cl == CL_EQ);
            end
            ST_INT: begin
               if (cl == CL_DIGIT) begin
                  mv = MV_APPEND; done = 1'b1;
               end else if (cl == CL_DOT) begin
                  mv = MV_APPEND; nxt = ST_DEC; done = 1'b1;
               end
               err = (cl == CL_EQ);
            end
            ST_DEC: begin
               if (cl == CL_DIGIT) begin
                  mv = MV_APPEND; nxt = ST_FRAC;
               end
               done = 1'b1;
            end
            ST_FRAC: begin
               if (cl == CL_DIGIT) begin
                  mv = MV_APPEND; done = 1'b1;
               end
               err = (cl == CL_DOT) || (cl == CL_EQ);
            end
            ST_NAME: begin
               if ((cl == CL_DIGIT) || (cl == CL_ALPHA)) begin
                  mv = MV_APPEND; done = 1'b1;
               end
               err = (cl == CL_DOT) || (cl == CL_EQ);
            end
            ST_OP: begin
               err = (cl == CL_DOT) || (cl == CL_EQ);
            end
            ST_LT1: begin
               if (cl == CL_EQ) begin
                  mv = MV_APPEND; nxt = ST_LT2; done = 1'b1;
               end
               err = (cl == CL_DIGIT) || (cl == CL_DOT);
            end
            ST_LT2: begin
               err = (cl == CL_EQ) || (cl == CL_DIGIT) || (cl == CL_DOT);
            end
            ST_GT1: begin
               if (cl == CL_EQ) begin
                  mv = MV_APPEND; nxt = ST_GT2; done = 1'b1;
               end
               err = (cl == CL_DOT);
            end
            ST_GT2: begin
               err = (cl == CL_DOT) || (cl == CL_EQ);
            end
            default: begin
               done = 1'b1;
            end
         endcase
         if (!done) begin
            if (err) begin
               mv = MV_ERR;
            end else if (cl == CL_WS) begin
               mv  = MV_CLOSE;
               nxt = ST_SPACE;
            end else begin
               mv = MV_NEW;
               unique case (cl)
                  CL_DIGIT: nxt = ST_INT;
                  CL_ALPHA: nxt = ST_NAME;
                  CL_OP:    nxt = ST_OP;
                  CL_LT:    nxt = ST_LT1;
                  default:  nxt = ST_GT1;
               endcase
            end
         end
      end
   end

   // a pending point left open by the last byte also rejects the string
   assign new_err = err_ff || (mv == MV_ERR) || (last && (nxt == ST_DEC));

   // next state
   always_comb begin
      st_in  = st_ff;
      err_in = err_ff;
      if (take) begin
         if (last) begin
            st_in  = ST_SPACE;
            err_in = 1'b0;
         end else begin
            if (!err_ff && (mv != MV_ERR)) begin
               st_in = nxt;
            end
            err_in = new_err;
         end
      end
   end

   // result fields
   always_comb begin
      res               = '0;
      res.char_echo     = link.item.char_in;
      res.end_of_string = last;
      res.failed        = new_err;
      res.action        = ACT_ERR;
      if (!err_ff) begin
         unique case (mv)
            MV_SKIP: begin
               res.action = ACT_SKIP;
            end
            MV_CLOSE: begin
               res.action       = ACT_SKIP;
               res.closes_prior = 1'b1;
               res.token_kind   = kind_of(st_ff);
            end
            MV_APPEND: begin
               res.action     = ACT_APPEND;
               res.token_kind = kind_of(nxt);
            end
            MV_NEW: begin
               res.action       = ACT_NEW;
               res.closes_prior = (st_ff != ST_SPACE);
               res.token_kind   = kind_of(nxt);
            end
            default: begin
               res.action = ACT_ERR;
            end
         endcase
         res.closes_at_end = last && !new_err && (nxt != ST_SPACE);
      end
   end

   // result queue
   assign empty  = (cnt_ff == 2'd0);
   assign do_pop = pop && !empty;
   assign rsp    = q_ff[rd_ff];

   always_comb begin
      wr_in  = take ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, take} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_SPACE;
         err_ff <= 1'b0;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         st_ff  <= st_in;
         err_ff <= err_in;
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         q_ff[wr_ff] <= res;
      end
   end

endmodule

>>> rtl/core/expression_lexer_fsm.sv
// Expression lexer: one byte in, one classified result out, per transfer.
// A pushed byte is held in the front queue, then its result in the result queue.
// Throughput: one byte per cycle while the result queue has room.
// Reset: synchronous, active high; empties both queues, lexer goes between tokens,
// error latch cleared. No clearing pass; push is taken the cycle after reset drops.
`timescale 1ns / 1ps

module expression_lexer_fsm
   import exl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_char_in,
   input  logic       req_is_last,
   // result channel
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_char_echo,
   output logic [1:0] rsp_action,
   output logic       rsp_closes_prior,
   output logic [2:0] rsp_token_kind,
   output logic       rsp_closes_at_end,
   output logic       rsp_failed,
   output logic       rsp_end_of_string
);

   // Front -> back link. The front classifies each byte on the way in and
   // buffers it; the back pulls one entry per cycle while its result queue
   // has room. Either side can stall without stopping the other while
   // the two-entry queues between them have room.
   link_type link;
   logic     take;
   rsp_type  rsp;

   exl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_char_in (req_char_in),
      .req_is_last (req_is_last),
      .link        (link),
      .take        (take)
   );

   // The back end owns the lexer state and error latch. On the last byte
   // of a string both return to their reset values, so strings may follow
   // one another with no gap.
   exl_back u_back (
      .clock (clock),
      .reset (reset),
      .link  (link),
      .take  (take),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp)
   );

   // result fields straight from the head of the result queue
   assign rsp_char_echo     = rsp.char_echo;
   assign rsp_action        = rsp.action;
   assign rsp_closes_prior  = rsp.closes_prior;
   assign rsp_token_kind    = rsp.token_kind;
   assign rsp_closes_at_end = rsp.closes_at_end;
   assign rsp_failed        = rsp.failed;
   assign rsp_end_of_string = rsp.end_of_string;

endmodule

>>> rtl/core/exl_checker.sv
// Port-level checker for the expression lexer, bound to the top level.
// Depends on exl_pkg and expression_lexer_fsm_assert.svh.
`timescale 1ns / 1ps
`include "expression_lexer_fsm_assert.svh"

module exl_checker
   import exl_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_char_echo,
   input logic [1:0] rsp_action,
   input logic       rsp_closes_at_end,
   input logic       rsp_failed,
   input logic       rsp_end_of_string
);

   `EXL_ASSERT_ALWAYS(a_reset_clears, reset |=> (empty && !full), "queues not empty after reset")
   `EXL_ASSERT(a_err_fails, (!empty && (rsp_action == ACT_ERR)) |-> rsp_failed, "error without failed")
   `EXL_ASSERT(a_end_close, (!empty && rsp_closes_at_end) |-> (rsp_end_of_string && !rsp_failed), "bad closes_at_end")
   `EXL_ASSERT(a_rsp_hold, (!empty && !pop) |=> (!empty && $stable(rsp_char_echo)), "result dropped while waiting")

endmodule

bind expression_lexer_fsm exl_checker u_exl_checker (
   .clock             (clock),
   .reset             (reset),
   .full              (full),
   .empty             (empty),
   .pop               (pop),
   .rsp_char_echo     (rsp_char_echo),
   .rsp_action        (rsp_action),
   .rsp_closes_at_end (rsp_closes_at_end),
   .rsp_failed        (rsp_failed),
   .rsp_end_of_string (rsp_end_of_string)
);

>>> verif/tb_top.sv
// Self-checking bench for expression_lexer_fsm: directed byte strings, then random
// expressions with noise, checked against an in-bench lexer model.
// Depends on exl_pkg (types, character codes, action and kind codes) and the lexer RTL.
`timescale 1ns / 1ps

module tb_top;
   import exl_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 10;
   localparam int TOTAL_ITEMS    = 2000;
   localparam int TAIL_ITEMS     = 300;   // no idling on either side for the last stretch
   localparam int HOLD_AT_ITEM   = 600;   // when the long receiver hold-off kicks in
   localparam int HOLD_CYCLES    = 64;
   localparam int DRAIN_CYCLES   = 8;     // waited after the last expected result
   localparam int WATCHDOG_LIMIT = 2000;  // well above the long receiver hold-off
   localparam int MAX_REPORTS    = 50;

   // ------------------------------------------------------------------------
   // Scoreboard: tracks the lexer state of the string in flight, predicts one
   // result per accepted byte and checks results in arrival order.
   // ------------------------------------------------------------------------
   class lexer_scoreboard;
      lex_state_type lex_st;
      bit            rejected;
      rsp_type       expected_results[$];
      int            mismatches;
      int            bytes_checked;
      int            strings_checked;
      int            action_seen[4];

      function new();
         lex_st     = ST_SPACE;
         rejected   = 1'b0;
         mismatches = 0;
         bytes_checked   = 0;
         strings_checked = 0;
         foreach (action_seen[i]) action_seen[i] = 0;
      endfunction

      function class_type char_group(logic [7:0] c);
         if (c >= CH_ZERO && c <= CH_NINE) return CL_DIGIT;
         if ((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z)) return CL_ALPHA;
         if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return CL_WS;
         if (c == CH_STAR || c == CH_PLUS || c == CH_MINUS || c == CH_SLASH ||
             c == CH_LPAREN || c == CH_RPAREN) return CL_OP;
         if (c == CH_DOT) return CL_DOT;
         if (c == CH_LT) return CL_LT;
         if (c == CH_GT) return CL_GT;
         if (c == CH_EQ) return CL_EQ;
         return CL_OTHER;
      endfunction

      function logic [2:0] open_kind(lex_state_type st);
         case (st)
            ST_DEC, ST_FRAC: return KIND_DEC;
            ST_NAME:         return KIND_NAME;
            ST_OP:           return KIND_OP;
            ST_LT1:          return KIND_LT;
            ST_LT2:          return KIND_LE;
            ST_GT1:          return KIND_GT;
            ST_GT2:          return KIND_GE;
            default:         return KIND_INT;
         endcase
      endfunction

      // one DFA move; nxt is only meaningful when the move is not an error
      function move_type dfa_step(lex_state_type st, class_type cl,
                                  output lex_state_type nxt);
         bit bad;
         bad = 1'b0;
         nxt = st;
         if (cl == CL_OTHER) return MV_ERR;
         case (st)
            ST_SPACE: begin
               if (cl == CL_WS) return MV_SKIP;
               bad = (cl == CL_DOT || cl == CL_EQ);
            end
            ST_INT: begin
               if (cl == CL_DIGIT) return MV_APPEND;
               if (cl == CL_DOT) begin
                  nxt = ST_DEC;
                  return MV_APPEND;
               end
               bad = (cl == CL_EQ);
            end
            ST_DEC: begin
               if (cl == CL_DIGIT) begin
                  nxt = ST_FRAC;
                  return MV_APPEND;
               end
               return MV_ERR;
            end
            ST_FRAC: begin
               if (cl == CL_DIGIT) return MV_APPEND;
               bad = (cl == CL_DOT || cl == CL_EQ);
            end
            ST_NAME: begin
               if (cl == CL_DIGIT || cl == CL_ALPHA) return MV_APPEND;
               bad = (cl == CL_DOT || cl == CL_EQ);
            end
            ST_OP: begin
               bad = (cl == CL_DOT || cl == CL_EQ);
            end
            ST_LT1: begin
               if (cl == CL_EQ) begin
                  nxt = ST_LT2;
                  return MV_APPEND;
               end
               bad = (cl == CL_DIGIT || cl == CL_DOT);
            end
            ST_LT2: begin
               bad = (cl == CL_EQ || cl == CL_DIGIT || cl == CL_DOT);
            end
            ST_GT1: begin
               if (cl == CL_EQ) begin
                  nxt = ST_GT2;
                  return MV_APPEND;
               end
               bad = (cl == CL_DOT);
            end
            ST_GT2: begin
               bad = (cl == CL_DOT || cl == CL_EQ);
            end
            default: begin
               return MV_ERR;
            end
         endcase
         if (bad) return MV_ERR;
         if (cl == CL_WS) begin
            nxt = ST_SPACE;
            return MV_CLOSE;
         end
         case (cl)
            CL_DIGIT: nxt = ST_INT;
            CL_ALPHA: nxt = ST_NAME;
            CL_OP:    nxt = ST_OP;
            CL_LT:    nxt = ST_LT1;
            default:  nxt = ST_GT1;
         endcase
         return MV_NEW;
      endfunction

      // called for every byte transfer into the block
      function void note_char(logic [7:0] c, logic last);
         rsp_type       want;
         lex_state_type nxt;
         move_type      mv;
         want = '0;
         want.char_echo     = c;
         want.action        = ACT_ERR;
         want.end_of_string = last;
         if (!rejected) begin
            mv = dfa_step(lex_st, char_group(c), nxt);
            case (mv)
               MV_SKIP: begin
                  want.action = ACT_SKIP;
               end
               MV_CLOSE: begin
                  want.action       = ACT_SKIP;
                  want.closes_prior = 1'b1;
                  want.token_kind   = open_kind(lex_st);
               end
               MV_APPEND: begin
                  want.action     = ACT_APPEND;
                  want.token_kind = open_kind(nxt);
               end
               MV_NEW: begin
                  want.action       = ACT_NEW;
                  want.closes_prior = (lex_st != ST_SPACE);
                  want.token_kind   = open_kind(nxt);
               end
               default: begin
                  rejected = 1'b1;
               end
            endcase
            if (!rejected) begin
               lex_st = nxt;
               // implicit trailing space: a dangling point is an error, anything
               // else that is open gets closed
               if (last) begin
                  if (nxt == ST_DEC) rejected = 1'b1;
                  else if (nxt != ST_SPACE) want.closes_at_end = 1'b1;
               end
            end
         end
         want.failed = rejected;
         expected_results.insert(expected_results.size(), want);
         if (last) begin
            lex_st   = ST_SPACE;
            rejected = 1'b0;
         end
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         end
      endfunction

      // called for every result transfer out of the block
      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected result, expected none, actual char %0d action %0d",
                        $time, got.char_echo, got.action);
            return;
         end
         want = expected_results.pop_front();
         bytes_checked++;
         action_seen[want.action]++;
         if (want.end_of_string) strings_checked++;
         compare_field("char_echo", want.char_echo, got.char_echo);
         compare_field("action", 8'(want.action), 8'(got.action));
         compare_field("closes_prior", 8'(want.closes_prior), 8'(got.closes_prior));
         compare_field("token_kind", 8'(want.token_kind), 8'(got.token_kind));
         compare_field("closes_at_end", 8'(want.closes_at_end), 8'(got.closes_at_end));
         compare_field("failed", 8'(want.failed), 8'(got.failed));
         compare_field("end_of_string", 8'(want.end_of_string), 8'(got.end_of_string));
      endfunction

      function int outstanding();
         return expected_results.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Clock, reset and block I/O. Every input has a known value from time 0.
   // ------------------------------------------------------------------------
   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       push        = 1'b0;
   logic       pop         = 1'b0;
   logic [7:0] req_char_in = '0;
   logic       req_is_last = 1'b0;
   logic       full;
   logic       empty;
   logic [7:0] rsp_char_echo;
   logic [1:0] rsp_action;
   logic       rsp_closes_prior;
   logic [2:0] rsp_token_kind;
   logic       rsp_closes_at_end;
   logic       rsp_failed;
   logic       rsp_end_of_string;
   rsp_type    seen_rsp;

   lexer_scoreboard sb;
   logic [7:0]      pending_text[$];   // bytes of the string about to be sent
   int              sent_count    = 0;
   int              input_stalls  = 0;   // cycles with push high and full high
   bit              quiet_tail    = 1'b0;
   bit              hold_request  = 1'b0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   expression_lexer_fsm dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_char_in       (req_char_in),
      .req_is_last       (req_is_last),
      .empty             (empty),
      .pop               (pop),
      .rsp_char_echo     (rsp_char_echo),
      .rsp_action        (rsp_action),
      .rsp_closes_prior  (rsp_closes_prior),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_closes_at_end (rsp_closes_at_end),
      .rsp_failed        (rsp_failed),
      .rsp_end_of_string (rsp_end_of_string)
   );

   assign seen_rsp = '{char_echo:     rsp_char_echo,
                       action:        rsp_action,
                       closes_prior:  rsp_closes_prior,
                       token_kind:    rsp_token_kind,
                       closes_at_end: rsp_closes_at_end,
                       failed:        rsp_failed,
                       end_of_string: rsp_end_of_string};

   // ------------------------------------------------------------------------
   // Monitor. Sampled at the rising edge, before any of this edge's updates land,
   // so both handshakes are seen exactly as the block sees them. The input
   // transfer is noted ahead of the result check of the same edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) sb.note_char(req_char_in, req_is_last);
         if (push && full) input_stalls++;
         if (pop && !empty) sb.check_result(seen_rsp);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Offer one byte and hold it until the block takes it. Entered right after a
   // rising edge; push stays high on return so back-to-back bytes need no toggle.
   task automatic offer_char(input logic [7:0] c, input logic last);
      push        <= 1'b1;
      req_char_in <= c;
      req_is_last <= last;
      @(posedge clock);
      while (full !== 1'b0) @(posedge clock);
   endtask

   // Send the pending string, last flag on its final byte, with random gaps before the tail.
   task automatic send_pending();
      for (int i = 0; i < pending_text.size(); i++) begin
         offer_char(pending_text[i], i == pending_text.size() - 1);
         sent_count++;
         if (!quiet_tail && $urandom_range(0, 6) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
      end
   endtask

   // append one byte to the string being built
   function automatic void add_byte(logic [7:0] b);
      pending_text.insert(pending_text.size(), b);
   endfunction

   function automatic void load_text(string s);
      pending_text.delete();
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic logic [7:0] rand_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_letter();
      return ($urandom_range(0, 1) != 0) ? CH_UP_A + 8'($urandom_range(0, 25))
                                         : CH_LO_A + 8'($urandom_range(0, 25));
   endfunction

   // space, or one of tab / LF / VT / FF / CR
   function automatic logic [7:0] rand_space();
      return ($urandom_range(0, 1) != 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
   endfunction

   // Append one well-formed token of a random kind.
   function automatic void add_token();
      logic [7:0] ops[6];
      ops = '{CH_STAR, CH_PLUS, CH_MINUS, CH_SLASH, CH_LPAREN, CH_RPAREN};
      case ($urandom_range(0, 7))
         0: begin
            repeat ($urandom_range(1, 4)) add_byte(rand_digit());
         end
         1: begin
            repeat ($urandom_range(1, 3)) add_byte(rand_digit());
            add_byte(CH_DOT);
            repeat ($urandom_range(1, 3)) add_byte(rand_digit());
         end
         2: begin
            add_byte(rand_letter());
            repeat ($urandom_range(0, 4))
               add_byte(($urandom_range(0, 1) != 0) ? rand_letter() : rand_digit());
         end
         3: begin
            add_byte(ops[$urandom_range(0, 5)]);
         end
         4: begin
            add_byte(CH_LT);
         end
         5: begin
            add_byte(CH_LT);
            add_byte(CH_EQ);
         end
         6: begin
            add_byte(CH_GT);
         end
         default: begin
            add_byte(CH_GT);
            add_byte(CH_EQ);
         end
      endcase
   endfunction

   // Mostly well-formed expressions; the rest have a stray byte, a stray point
   // or equals sign, or are plain noise over the full byte range.
   function automatic void build_string();
      int flavor;
      int tokens;
      pending_text.delete();
      flavor = $urandom_range(0, 9);
      if (flavor == 0) begin
         repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
         return;
      end
      tokens = $urandom_range(1, 8);
      if ($urandom_range(0, 3) == 0) add_byte(rand_space());
      repeat (tokens) begin
         add_token();
         if ($urandom_range(0, 1) != 0)
            repeat ($urandom_range(1, 2)) add_byte(rand_space());
      end
      if (flavor == 1)
         pending_text.insert($urandom_range(0, pending_text.size()),
                             8'($urandom_range(0, 255)));
      else if (flavor == 2)
         pending_text.insert($urandom_range(0, pending_text.size()),
                             ($urandom_range(0, 1) != 0) ? CH_DOT : CH_EQ);
   endfunction

   // ------------------------------------------------------------------------
   // Result side pacing: random stall bursts, one long hold-off on request so
   // the block backs up and pushes back on the sender, nothing in the tail.
   // ------------------------------------------------------------------------
   initial begin : result_pacing
      int stall_left;
      int hold_left;
      bit hold_taken;
      stall_left = 0;
      hold_left  = 0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 10);
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: ends the run if no transfer happens on either side for too long.
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (push && !full) || (pop && !empty)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("%0t: no transfer for %0d cycles, %0d results still expected",
               $time, WATCHDOG_LIMIT, sb.outstanding());
      $display("tb_top failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed strings. Name, less-or-equal, integer growing into a decimal
      // that the end of the string closes.
      load_text("x1<=3.25");
      send_pending();
      // operator after operator: each is a token of its own
      load_text("(-)");
      send_pending();
      // whitespace close, greater-or-equal, greater left open at the end
      load_text("b >=c>");
      send_pending();
      // decimal point still waiting for a digit on the last byte
      load_text("7.");
      send_pending();
      // equals after an integer, error on the last byte
      load_text("9=");
      send_pending();
      // digit right after less-than
      load_text("<5");
      send_pending();
      // byte outside every class, then bytes after the error
      pending_text = '{8'h00, 8'hFF, CH_STAR};
      send_pending();

      // Random strings until the item budget is used up.
      while (sent_count < TOTAL_ITEMS) begin
         if (sent_count >= HOLD_AT_ITEM) hold_request = 1'b1;
         if (sent_count >= TOTAL_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
         build_string();
         send_pending();
      end
      push <= 1'b0;

      // Drain: the watchdog catches a result that never shows up.
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Lexed %0d bytes in %0d strings: %0d skipped, %0d appended, %0d new, %0d errors",
               sb.bytes_checked, sb.strings_checked, sb.action_seen[ACT_SKIP],
               sb.action_seen[ACT_APPEND], sb.action_seen[ACT_NEW], sb.action_seen[ACT_ERR]);
      $display("Input held back by a full block for %0d cycles; %0d field mismatches",
               input_stalls, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/exl_pkg.sv
rtl/core/exl_front.sv
rtl/core/exl_back.sv
rtl/core/expression_lexer_fsm.sv
rtl/core/exl_checker.sv
verif/tb_top.sv
